/* rtl/core/sfum_pkg.sv */
// shared constants, register codes and helper functions for the stereo frame unpack mapper
package sfum_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int IN_W           = 12;
	localparam int PIX_W          = 32;
	localparam int FMT_W          = 3;
	localparam int DIM_W          = 13;
	localparam int CFG_IDX_W      = 2;
	localparam int DIV_W          = 16;

	localparam logic [FMT_W-1:0] FMT_MONO     = 3'd0;
	localparam logic [FMT_W-1:0] FMT_SBS_RL   = 3'd1;
	localparam logic [FMT_W-1:0] FMT_PAR_LR   = 3'd2;
	localparam logic [FMT_W-1:0] FMT_OU_RL    = 3'd3;
	localparam logic [FMT_W-1:0] FMT_OU_LR    = 3'd4;
	localparam logic [FMT_W-1:0] FMT_ROW_IL   = 3'd5;
	localparam logic [FMT_W-1:0] FMT_SEPARATE = 3'd6;
	localparam logic [FMT_W-1:0] FMT_TILED4X  = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_FORMAT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_DOWN = 2'd3;

	localparam logic [FMT_W-1:0] RST_FORMAT   = FMT_MONO;
	localparam logic [DIM_W-1:0] RST_WIDTH    = 13'd1920;
	localparam logic [DIM_W-1:0] RST_HEIGHT   = 13'd1080;
	localparam logic             RST_TOP_DOWN = 1'b1;

	// limit a frame dimension to 2^coord_bits
	function automatic logic [DIV_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input int coord_bits);
		logic [DIV_W-1:0] lim;
		logic [DIV_W-1:0] ext;
		lim = DIV_W'(1) << coord_bits;
		ext = DIV_W'(v);
		return (ext > lim) ? lim : ext;
	endfunction

	// floor(v/3) by reciprocal multiply, exact below 2^15
	function automatic logic [DIV_W-1:0] div3(input logic [DIV_W-1:0] v);
		logic [2*DIV_W-1:0] prod;
		prod = {{DIV_W{1'b0}}, v} * (2*DIV_W)'(21846);
		return prod[2*DIV_W-1:DIV_W];
	endfunction

endpackage

/* rtl/core/sfum_if.sv */
// valid/ready channel interfaces for source pixels and mapped pixels
interface sfum_src_if import sfum_pkg::*;;
	logic             valid;
	logic             ready;
	logic [IN_W-1:0]  src_x;
	logic [IN_W-1:0]  src_y;
	logic             from_second_frame;
	logic [PIX_W-1:0] in_pixel;

	modport source (output valid, src_x, src_y, from_second_frame, in_pixel, input ready);
	modport sink (input valid, src_x, src_y, from_second_frame, in_pixel, output ready);
endinterface

interface sfum_dst_if import sfum_pkg::*;;
	logic             valid;
	logic             ready;
	logic             to_right_view;
	logic [IN_W-1:0]  dest_x;
	logic [IN_W-1:0]  dest_y;
	logic [PIX_W-1:0] out_pixel;

	modport source (output valid, to_right_view, dest_x, dest_y, out_pixel, input ready);
	modport sink (input valid, to_right_view, dest_x, dest_y, out_pixel, output ready);
endinterface

/* rtl/core/stereo_frame_unpack_mapper.sv */
// stereo frame unpack mapper: routes source pixels to left/right views with top-down coordinates
//
//  port    dir   payload                                        transaction
//  src     in    src_x, src_y, from_second_frame, in_pixel      valid & ready
//  dst     out   to_right_view, dest_x, dest_y, out_pixel       valid & ready
//  cfg     in    cfg_index, cfg_wdata                           cfg_we
//
//  one pixel per cycle sustained while dst does not stall; a src transaction is
//  registered in the input register, mapped, and registered again in the result
//  register, which drives dst (input register, mapping logic, result register)
//  dropped pixels free their slot and produce no dst transaction
//  a dst stall holds the result register and then the input register; src.ready
//  stays high while either register can move on
//  arst_n clears both valid bits and loads the register reset values
module stereo_frame_unpack_mapper
	import sfum_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_wdata,
	sfum_src_if.sink             src,
	sfum_dst_if.source           dst
);

	localparam int CW = COORD_BITS + 1;
	localparam int AW = (CW > IN_W) ? CW : IN_W;
	localparam logic [AW-1:0] OUT_MASK = AW'((1 << COORD_BITS) - 1);

	localparam logic [DIV_W-1:0] RW_DIM   = clamp_dim(RST_WIDTH, COORD_BITS);
	localparam logic [DIV_W-1:0] RW_THIRD = div3(RW_DIM);
	localparam logic [DIV_W-1:0] RH_DIM   = clamp_dim(RST_HEIGHT, COORD_BITS);
	localparam logic [DIV_W-1:0] RH_THIRD = div3(RH_DIM);

	// configuration and derived dimensions
	logic [FMT_W-1:0] fmt_q;
	logic             td_q;
	logic [CW-1:0]    w_q, wh_q, wt_q, w2t_q, w3t_q;
	logic [CW-1:0]    h_q, hh_q, ht_q, h2t_q, h3t_q;

	logic [DIV_W-1:0] dim_nxt;
	logic [DIV_W-1:0] third_nxt;

	assign dim_nxt   = clamp_dim(cfg_wdata, COORD_BITS);
	assign third_nxt = div3(dim_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= RST_FORMAT;
			td_q  <= RST_TOP_DOWN;
			w_q   <= CW'(RW_DIM);
			wh_q  <= CW'(RW_DIM >> 1);
			wt_q  <= CW'(RW_THIRD);
			w2t_q <= CW'(RW_THIRD << 1);
			w3t_q <= CW'(RW_THIRD + (RW_THIRD << 1));
			h_q   <= CW'(RH_DIM);
			hh_q  <= CW'(RH_DIM >> 1);
			ht_q  <= CW'(RH_THIRD);
			h2t_q <= CW'(RH_THIRD << 1);
			h3t_q <= CW'(RH_THIRD + (RH_THIRD << 1));
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FORMAT: begin
					fmt_q <= cfg_wdata[FMT_W-1:0];
				end
				REG_WIDTH: begin
					w_q   <= CW'(dim_nxt);
					wh_q  <= CW'(dim_nxt >> 1);
					wt_q  <= CW'(third_nxt);
					w2t_q <= CW'(third_nxt << 1);
					w3t_q <= CW'(third_nxt + (third_nxt << 1));
				end
				REG_HEIGHT: begin
					h_q   <= CW'(dim_nxt);
					hh_q  <= CW'(dim_nxt >> 1);
					ht_q  <= CW'(third_nxt);
					h2t_q <= CW'(third_nxt << 1);
					h3t_q <= CW'(third_nxt + (third_nxt << 1));
				end
				REG_TOP_DOWN: begin
					td_q <= cfg_wdata[0];
				end
			endcase
		end
	end

	// input register
	logic             vld_s1;
	logic [IN_W-1:0]  x_s1, y_s1;
	logic             sec_s1;
	logic [PIX_W-1:0] pix_s1;

	// result register
	logic             vld_s2;
	logic             right_s2;
	logic [IN_W-1:0]  dx_s2, dy_s2;
	logic [PIX_W-1:0] pix_s2;

	logic s2_free;
	logic adv;

	assign s2_free   = !vld_s2 || dst.ready;
	assign adv       = vld_s1 && s2_free;
	assign src.ready = !vld_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (src.ready) begin
			vld_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src.valid && src.ready) begin
			x_s1   <= src.src_x;
			y_s1   <= src.src_y;
			sec_s1 <= src.from_second_frame;
			pix_s1 <= src.in_pixel;
		end
	end

	// mapping
	logic [AW-1:0] xe, ye, we, he, whe, hhe;
	logic [AW-1:0] sx, sxe, hx4, sy, sye, hy4;
	logic [AW-1:0] t;
	logic [AW-1:0] dx, dy;
	logic          right;
	logic          keep;
	logic          first;

	assign xe  = AW'(x_s1);
	assign ye  = AW'(y_s1);
	assign we  = AW'(w_q);
	assign he  = AW'(h_q);
	assign whe = AW'(wh_q);
	assign hhe = AW'(hh_q);
	assign hx4 = AW'(wt_q);
	assign sx  = AW'(w2t_q);
	assign sxe = AW'(w3t_q);
	assign hy4 = AW'(ht_q);
	assign sy  = AW'(h2t_q);
	assign sye = AW'(h3t_q);
	assign t   = td_q ? ye : (he - AW'(1) - ye);

	always_comb begin
		keep  = 1'b1;
		right = 1'b0;
		first = 1'b0;
		dx    = xe;
		dy    = t;
		if (xe >= we || ye >= he) begin
			keep = 1'b0;
		end
		if (sec_s1 && fmt_q != FMT_SEPARATE) begin
			keep = 1'b0;
		end
		unique case (fmt_q)
			FMT_MONO: begin
				right = 1'b0;
			end
			FMT_SBS_RL, FMT_PAR_LR: begin
				first = xe < whe;
				if (xe >= (whe << 1)) begin
					keep = 1'b0;
				end
				dx    = first ? xe : (xe - whe);
				right = (fmt_q == FMT_PAR_LR) ? !first : first;
			end
			FMT_OU_RL, FMT_OU_LR: begin
				if (ye >= (hhe << 1)) begin
					keep = 1'b0;
				end
				if (td_q) begin
					first = ye < hhe;
					dy    = first ? ye : (ye - hhe);
				end else begin
					first = ye >= hhe;
					dy    = first ? ((hhe << 1) - AW'(1) - ye) : (hhe - AW'(1) - ye);
				end
				right = (fmt_q == FMT_OU_LR) ? !first : first;
			end
			FMT_ROW_IL: begin
				if (ye >= (hhe << 1)) begin
					keep = 1'b0;
				end
				if (td_q) begin
					right = ye[0];
					dy    = ye >> 1;
				end else begin
					right = !ye[0];
					dy    = hhe - AW'(1) - (ye >> 1);
				end
			end
			FMT_SEPARATE: begin
				right = sec_s1;
			end
			FMT_TILED4X: begin
				if (t < sy) begin
					if (xe < sx) begin
						right = 1'b0;
					end else if (xe < sxe) begin
						right = 1'b1;
						dx    = xe - sx;
					end else begin
						keep = 1'b0;
					end
				end else if (t < sye) begin
					if (xe < hx4) begin
						right = 1'b1;
						dx    = xe + hx4;
						dy    = t - sy;
					end else if (xe < sx) begin
						right = 1'b1;
						dy    = (t - sy) + hy4;
					end else begin
						keep = 1'b0;
					end
				end else begin
					keep = 1'b0;
				end
			end
		endcase
	end

	logic [AW-1:0] dx_m, dy_m;

	assign dx_m = dx & OUT_MASK;
	assign dy_m = dy & OUT_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_free) begin
			vld_s2 <= adv && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			right_s2 <= right;
			dx_s2    <= dx_m[IN_W-1:0];
			dy_s2    <= dy_m[IN_W-1:0];
			pix_s2   <= pix_s1;
		end
	end

	assign dst.valid         = vld_s2;
	assign dst.to_right_view = right_s2;
	assign dst.dest_x        = dx_s2;
	assign dst.dest_y        = dy_s2;
	assign dst.out_pixel     = pix_s2;

`ifndef SYNTH
	a_src_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		src.valid && src.ready |=> vld_s1)
		else $error("accepted transaction missing from input register");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !s2_free |=> vld_s1 && $stable(x_s1) && $stable(y_s1) && $stable(pix_s1))
		else $error("input register changed during stall");

	a_keep_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && keep |=> dst.valid && dst.out_pixel == $past(pix_s1))
		else $error("kept pixel not presented on dst");

	a_second_drop: assert property (@(posedge clk) disable iff (!arst_n)
		adv && sec_s1 && fmt_q != FMT_SEPARATE |=> !dst.valid)
		else $error("second-frame pixel passed in packed mode");
`endif

endmodule

/* test/tb_stereo_frame_unpack_mapper.sv */
// testbench for stereo_frame_unpack_mapper: directed and random pixel streams checked by a mapping scoreboard
`timescale 1ns / 100ps

import sfum_pkg::*;

localparam int VIEW_LIM = 1 << COORD_BITS_DEF;

typedef struct packed {
	logic [IN_W-1:0]  x;
	logic [IN_W-1:0]  y;
	logic             second;
	logic [PIX_W-1:0] pix;
} src_pixel_t;

typedef struct packed {
	logic             right;
	logic [IN_W-1:0]  dx;
	logic [IN_W-1:0]  dy;
	logic [PIX_W-1:0] pix;
} view_pixel_t;

class view_scoreboard;
	logic [FMT_W-1:0] fmt = RST_FORMAT;
	int unsigned width = 32'(RST_WIDTH);
	int unsigned height = 32'(RST_HEIGHT);
	bit top_down = RST_TOP_DOWN;
	view_pixel_t expected_q[$];
	int errors = 0;

	function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
		case (idx)
		REG_FORMAT:   fmt = v[FMT_W-1:0];
		REG_WIDTH:    width = 32'(v);
		REG_HEIGHT:   height = 32'(v);
		REG_TOP_DOWN: top_down = v[0];
		default:      ;
		endcase
	endfunction

	function bit map_pixel(input src_pixel_t p, output view_pixel_t r);
		int w, h, x, y, t, hx, hy, sx, sy, dx, dy;
		bit first, right;
		r = '0;
		w = (width > VIEW_LIM) ? VIEW_LIM : width;
		h = (height > VIEW_LIM) ? VIEW_LIM : height;
		x = 32'(p.x);
		y = 32'(p.y);
		if (x >= w || y >= h)
			return 0;
		if (p.second && fmt != FMT_SEPARATE)
			return 0;
		t = top_down ? y : h - 1 - y;
		right = 1'b0;
		dx = x;
		dy = t;
		case (fmt)
		FMT_SBS_RL, FMT_PAR_LR: begin
			hx = w / 2;
			if (x >= 2 * hx)
				return 0;
			first = x < hx;
			dx = first ? x : x - hx;
			right = (fmt == FMT_PAR_LR) ? !first : first;
		end
		FMT_OU_RL, FMT_OU_LR: begin
			hy = h / 2;
			if (y >= 2 * hy)
				return 0;
			if (top_down) begin
				first = y < hy;
				dy = first ? y : y - hy;
			end else begin
				first = y >= hy;
				dy = first ? 2 * hy - 1 - y : hy - 1 - y;
			end
			right = (fmt == FMT_OU_LR) ? !first : first;
		end
		FMT_ROW_IL: begin
			hy = h / 2;
			if (y >= 2 * hy)
				return 0;
			if (top_down) begin
				right = y[0];
				dy = y / 2;
			end else begin
				right = !y[0];
				dy = hy - 1 - y / 2;
			end
		end
		FMT_SEPARATE: right = p.second;
		FMT_TILED4X: begin
			sx = (w / 3) * 2;
			sy = (h / 3) * 2;
			hx = sx / 2;
			hy = sy / 2;
			if (t < sy) begin
				if (x >= sx + hx)
					return 0;
				if (x >= sx) begin
					right = 1'b1;
					dx = x - sx;
				end
			end else if (t < sy + hy) begin
				if (x >= sx)
					return 0;
				right = 1'b1;
				if (x < hx) begin
					dx = x + hx;
					dy = t - sy;
				end else begin
					dy = t - sy + hy;
				end
			end else begin
				return 0;
			end
		end
		default: right = 1'b0;
		endcase
		r.right = right;
		r.dx = dx[IN_W-1:0];
		r.dy = dy[IN_W-1:0];
		r.pix = p.pix;
		return 1;
	endfunction

	function void note_source(input src_pixel_t p);
		view_pixel_t r;
		if (map_pixel(p, r))
			expected_q.push_back(r);
	endfunction

	function void check_result(input view_pixel_t got);
		view_pixel_t want;
		if (expected_q.size() == 0) begin
			$error("unexpected transaction: view %0d x %0d y %0d pixel %h",
				got.right, got.dx, got.dy, got.pix);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		if (got.right !== want.right) begin
			$error("to_right_view: expected %0d, got %0d", want.right, got.right);
			errors++;
		end
		if (got.dx !== want.dx) begin
			$error("dest_x: expected %0d, got %0d", want.dx, got.dx);
			errors++;
		end
		if (got.dy !== want.dy) begin
			$error("dest_y: expected %0d, got %0d", want.dy, got.dy);
			errors++;
		end
		if (got.pix !== want.pix) begin
			$error("out_pixel: expected %h, got %h", want.pix, got.pix);
			errors++;
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb_stereo_frame_unpack_mapper;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_wdata;
	bit                   calm;
	bit                   hold_dst;
	view_scoreboard       sb;

	sfum_src_if src_ch();
	sfum_dst_if dst_ch();

	stereo_frame_unpack_mapper u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.src       (src_ch),
		.dst       (dst_ch)
	);

	always #10 clk = ~clk;

	function automatic src_pixel_t pixel_at(input int x, input int y, input bit second,
		input logic [PIX_W-1:0] pix);
		src_pixel_t p;
		p.x = x[IN_W-1:0];
		p.y = y[IN_W-1:0];
		p.second = second;
		p.pix = pix;
		return p;
	endfunction

	function automatic int unsigned pick_dim();
		case ($urandom_range(0, 19))
		0:       return 0;
		1:       return 1;
		2:       return 2;
		3:       return 3;
		4:       return VIEW_LIM;
		5:       return $urandom_range(VIEW_LIM + 1, 8191);
		6:       return 8191;
		default: return $urandom_range(4, 48);
		endcase
	endfunction

	function automatic src_pixel_t roll_pixel(input int unsigned w, input int unsigned h,
		input logic [FMT_W-1:0] fmt);
		src_pixel_t p;
		int unsigned cw, ch;
		cw = (w > VIEW_LIM) ? VIEW_LIM : w;
		ch = (h > VIEW_LIM) ? VIEW_LIM : h;
		p.pix = $urandom;
		if ($urandom_range(0, 99) < 80 && cw > 0 && ch > 0) begin
			p.x = IN_W'($urandom_range(0, cw - 1));
			p.y = IN_W'($urandom_range(0, ch - 1));
			p.second = (fmt == FMT_SEPARATE) ? 1'($urandom_range(0, 1))
				: ($urandom_range(0, 19) == 0);
		end else begin
			p.x = IN_W'($urandom_range(0, VIEW_LIM - 1));
			p.y = IN_W'($urandom_range(0, VIEW_LIM - 1));
			p.second = 1'($urandom_range(0, 1));
		end
		return p;
	endfunction

	task automatic send_pixel(input src_pixel_t p);
		while (!calm && $urandom_range(0, 99) < 25) begin
			src_ch.valid <= 1'b0;
			@(posedge clk);
		end
		src_ch.valid <= 1'b1;
		src_ch.src_x <= p.x;
		src_ch.src_y <= p.y;
		src_ch.from_second_frame <= p.second;
		src_ch.in_pixel <= p.pix;
		do
			@(posedge clk);
		while (!src_ch.ready);
		sb.note_source(p);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	// wait for the pipeline to drain, then load a full frame setup
	task automatic settle_and_load(input logic [FMT_W-1:0] fmt, input int unsigned w,
		input int unsigned h, input bit td);
		src_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		put_reg(REG_FORMAT, DIM_W'(fmt));
		put_reg(REG_WIDTH, DIM_W'(w));
		put_reg(REG_HEIGHT, DIM_W'(h));
		put_reg(REG_TOP_DOWN, DIM_W'(td));
		cfg_we <= 1'b0;
	endtask

	// receiver: checks transactions and throttles ready
	initial begin
		view_pixel_t got;
		dst_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (dst_ch.valid && dst_ch.ready) begin
				got.right = dst_ch.to_right_view;
				got.dx = dst_ch.dest_x;
				got.dy = dst_ch.dest_y;
				got.pix = dst_ch.out_pixel;
				sb.check_result(got);
			end
			if (hold_dst) begin
				hold_dst = 1'b0;
				dst_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			dst_ch.ready <= calm || $urandom_range(0, 99) >= 25;
		end
	end

	initial begin
		#4_000_000;
		$display("** stereo_frame_unpack_mapper: FAILED **");
		$finish;
	end

	initial begin
		int ph;
		logic [FMT_W-1:0] fmt;
		int unsigned w, h;
		bit td;
		sb = new;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FORMAT;
		cfg_wdata = '0;
		calm = 1'b0;
		hold_dst = 1'b0;
		src_ch.valid = 1'b0;
		src_ch.src_x = '0;
		src_ch.src_y = '0;
		src_ch.from_second_frame = 1'b0;
		src_ch.in_pixel = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setup: mono 1920x1080 top-down
		send_pixel(pixel_at(0, 0, 1'b0, 32'h0000_0000));
		send_pixel(pixel_at(1919, 1079, 1'b0, 32'hffff_ffff));
		send_pixel(pixel_at(1920, 5, 1'b0, 32'ha5a5_a5a5));
		send_pixel(pixel_at(5, 1080, 1'b0, 32'h5a5a_5a5a));
		send_pixel(pixel_at(4095, 4095, 1'b0, 32'h1234_5678));
		send_pixel(pixel_at(100, 200, 1'b1, 32'h8765_4321));
		send_pixel(pixel_at(2047, 1023, 1'b0, 32'hdead_beef));
		send_pixel(pixel_at(1, 1, 1'b0, 32'h0f0f_0f0f));

		// tiled areas in bottom-up order, including unused area
		settle_and_load(FMT_TILED4X, 9, 9, 1'b0);
		send_pixel(pixel_at(0, 0, 1'b0, $urandom));
		send_pixel(pixel_at(4, 0, 1'b0, $urandom));
		send_pixel(pixel_at(7, 0, 1'b0, $urandom));
		send_pixel(pixel_at(7, 5, 1'b0, $urandom));
		send_pixel(pixel_at(2, 6, 1'b0, $urandom));

		// odd leftover row in bottom-up interlace
		settle_and_load(FMT_ROW_IL, 5, 5, 1'b0);
		send_pixel(pixel_at(1, 4, 1'b0, $urandom));
		send_pixel(pixel_at(1, 3, 1'b0, $urandom));
		send_pixel(pixel_at(0, 0, 1'b0, $urandom));

		// zero height drops everything
		settle_and_load(FMT_MONO, 8191, 0, 1'b1);
		send_pixel(pixel_at(0, 0, 1'b0, $urandom));

		// oversized frame acts as full coordinate range
		settle_and_load(FMT_SEPARATE, 8191, VIEW_LIM + 1, 1'b1);
		send_pixel(pixel_at(4095, 4095, 1'b1, $urandom));
		send_pixel(pixel_at(0, 4095, 1'b0, $urandom));

		// odd leftover column in side-by-side
		settle_and_load(FMT_SBS_RL, 5, 3, 1'b1);
		send_pixel(pixel_at(4, 0, 1'b0, $urandom));
		send_pixel(pixel_at(2, 1, 1'b0, $urandom));

		for (ph = 0; ph < 20; ph++) begin
			if (ph < 16) begin
				fmt = FMT_W'(ph % 8);
				td = (ph / 8) != 0;
			end else begin
				fmt = FMT_W'($urandom_range(0, 7));
				td = 1'($urandom_range(0, 1));
			end
			w = pick_dim();
			h = pick_dim();
			if (ph == 2) begin
				w = 33;
				h = 17;
			end
			settle_and_load(fmt, w, h, td);
			calm = (ph == 9 || ph == 10);
			if (ph == 2)
				hold_dst = 1'b1;
			repeat (85) send_pixel(roll_pixel(w, h, fmt));
		end
		src_ch.valid <= 1'b0;

		calm = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("** stereo_frame_unpack_mapper: PASSED **");
		else
			$display("** stereo_frame_unpack_mapper: FAILED **");
		$finish;
	end

endmodule
